### rtl/core/assert_macros.svh
// assertion macros shared by the set core
// depends on clk and arst_n being visible in the module that expands them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every edge outside reset
`define DHS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// overlapping implication checked on every edge outside reset
`define DHS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### rtl/core/dhs_pkg.sv
// constants, codes and the residue fold function of the double hashing set
// no dependencies
package dhs_pkg;

	localparam int SLOTS    = 8;
	localparam int STEP_MOD = 5;

	localparam int KEY_W    = 31;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int ELEM_W   = 4;
	localparam int MARK_W   = 2;
	localparam int ENTRY_W  = MARK_W + KEY_W;

	localparam int IDX_W    = $clog2(SLOTS);
	localparam int CNT_W    = $clog2(SLOTS + 1);

	// residue unit sizing
	localparam int MAX_MOD     = (SLOTS > STEP_MOD) ? SLOTS : STEP_MOD;
	localparam int RES_W       = $clog2(MAX_MOD + 1);
	localparam int DIG_W       = 4;
	localparam int KEY_DIGITS  = (KEY_W + DIG_W - 1) / DIG_W;
	localparam int PAD_W       = KEY_DIGITS * DIG_W;
	localparam int DCNT_W      = $clog2(KEY_DIGITS + 1);
	localparam int STEP_W      = $clog2(2 * STEP_MOD);
	localparam int STEP_DIGITS = (STEP_W + DIG_W - 1) / DIG_W;
	localparam int STEP_PAD_W  = STEP_DIGITS * DIG_W;

	// operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

	// slot marks
	localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
	localparam logic [MARK_W-1:0] MARK_USED    = 2'd1;
	localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

	// shift one digit into a running residue, one compare-subtract per bit
	function automatic logic [RES_W-1:0] fold_digit(input logic [RES_W-1:0] r,
			input logic [DIG_W-1:0] d, input logic [RES_W-1:0] m);
		logic [RES_W:0]   t;
		logic [RES_W-1:0] acc;
		acc = r;
		for (int b = DIG_W - 1; b >= 0; b--) begin
			t = {acc, d[b]};
			if (t >= {1'b0, m}) begin
				t = t - {1'b0, m};
			end
			acc = t[RES_W-1:0];
		end
		return acc;
	endfunction

endpackage

### rtl/core/dhs_if.sv
// request and response channel interfaces of the double hashing set
// depends on dhs_pkg
interface dhs_req_if;
	import dhs_pkg::*;
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  op;
	logic [KEY_W-1:0] key;
	modport source (output valid, op, key, input ready);
	modport sink (input valid, op, key, output ready);
endinterface

interface dhs_rsp_if;
	import dhs_pkg::*;
	logic                valid;
	logic                ready;
	logic                was_present;
	logic [STATUS_W-1:0] status;
	logic [ELEM_W-1:0]   element_count;
	modport source (output valid, was_present, status, element_count, input ready);
	modport sink (input valid, was_present, status, element_count, output ready);
endinterface

### rtl/core/double_hash_open_address_set.sv
// top level of the double hashing open address key set
// depends on dhs_pkg, dhs_if, dhs_ram, dhs_residue and assert_macros.svh
//
// usage: a request on req carries op (insert if absent, delete, lookup) and a
// 31-bit key; every request gives exactly one response on rsp with
// was_present, status and the element count after the operation.
// flow: after the accepting edge the key is reduced mod SLOTS and mod
// STEP_MOD four bits a cycle, then the probe stride is reduced mod SLOTS,
// then the probe walk reads one slot a cycle from the slot ram until a
// slot ends the walk, and the response is loaded. Unused op code 3 skips
// the table and goes straight to the response. One request is worked at a
// time; req is ready again from the edge that loads the response.
// stall: the response register holds while rsp.ready is low; the next
// request is still taken and worked, and waits at its end until the
// register frees.
// reset: arst_n clears the count, the response valid and the per-slot valid
// bits, so every slot reads as empty at once; no clearing pass is needed.
module double_hash_open_address_set (
	input logic   clk,
	input logic   arst_n,
	dhs_req_if.sink   req,
	dhs_rsp_if.source rsp
);
	import dhs_pkg::*;
	`include "assert_macros.svh"

	typedef enum logic [2:0] {S_IDLE, S_RES, S_STEP, S_PROBE, S_FIN} state_t;

	state_t              state_q;
	logic [OP_W-1:0]     op_q;
	logic [KEY_W-1:0]    key_q;
	logic [IDX_W-1:0]    inc_q;      // probe stride mod SLOTS
	logic [IDX_W-1:0]    idx_q;      // slot address being read
	logic [IDX_W-1:0]    i_q;        // probe number being read
	logic                chk_v_s1;   // read data below is valid
	logic [IDX_W-1:0]    chk_idx_s1;
	logic [IDX_W-1:0]    i_s1;
	logic                free_found_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic [SLOTS-1:0]    valid_q;    // slot written since reset
	logic [CNT_W-1:0]    count_q;
	logic                res_present_q;
	logic [STATUS_W-1:0] res_status_q;
	logic                rsp_valid_q;
	logic                out_present_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [ELEM_W-1:0]   out_count_q;

	// residue units
	logic                start_key;
	logic                start_step;
	logic                res_busy_a;
	logic                res_busy_b;
	logic [RES_W-1:0]    res_a;
	logic [RES_W-1:0]    res_b;
	logic [STEP_W-1:0]   step_val;
	logic [PAD_W-1:0]    step_word;
	logic [PAD_W-1:0]    a_value;
	logic [DCNT_W-1:0]   a_digits;

	// slot ram
	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [ENTRY_W-1:0]  ram_wdata;
	logic [ENTRY_W-1:0]  ram_rdata;

	// probe check
	logic [MARK_W-1:0]   mark;
	logic                used;
	logic                match;
	logic                term;
	logic                can_place;
	logic [IDX_W-1:0]    place_idx;
	logic                do_insert;
	logic                do_delete;
	logic [IDX_W:0]      idx_sum;
	logic [IDX_W-1:0]    idx_next;
	logic                accept;
	logic                out_free;

	assign accept   = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;

	// a valid opcode starts both key residues; unit a is then reused for the stride
	always_comb begin
		start_key = 1'b0;
		if (accept) begin
			case (req.op)
				OP_INSERT, OP_DELETE, OP_LOOKUP: start_key = 1'b1;
				default:                         start_key = 1'b0;
			endcase
		end
	end

	assign start_step = (state_q == S_RES) && !res_busy_a && !res_busy_b;
	assign step_val   = STEP_W'({res_b, 1'b1});
	assign step_word  = PAD_W'(step_val) << (PAD_W - STEP_PAD_W);
	assign a_value    = start_key ? PAD_W'(req.key) : step_word;
	assign a_digits   = start_key ? DCNT_W'(KEY_DIGITS) : DCNT_W'(STEP_DIGITS);

	dhs_residue u_res_slots (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_key || start_step),
		.value   (a_value),
		.digits  (a_digits),
		.modulus (RES_W'(SLOTS)),
		.busy    (res_busy_a),
		.res     (res_a)
	);

	dhs_residue u_res_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_key),
		.value   (PAD_W'(req.key)),
		.digits  (DCNT_W'(KEY_DIGITS)),
		.modulus (RES_W'(STEP_MOD)),
		.busy    (res_busy_b),
		.res     (res_b)
	);

	// next probe address, one compare-subtract since both terms are below SLOTS
	always_comb begin
		idx_sum = {1'b0, idx_q} + {1'b0, inc_q};
		if (idx_sum >= (IDX_W + 1)'(SLOTS)) begin
			idx_sum = idx_sum - (IDX_W + 1)'(SLOTS);
		end
		idx_next = idx_sum[IDX_W-1:0];
	end

	// examine the slot read on the previous cycle; never written reads as empty
	always_comb begin
		mark      = valid_q[chk_idx_s1] ? ram_rdata[ENTRY_W-1 -: MARK_W] : MARK_EMPTY;
		used      = (mark == MARK_USED);
		match     = used && (ram_rdata[KEY_W-1:0] == key_q);
		term      = chk_v_s1 && (match || (!used && mark != MARK_DELETED)
			|| i_s1 == IDX_W'(SLOTS - 1));
		can_place = free_found_q || !used;
		place_idx = free_found_q ? free_idx_q : chk_idx_s1;
		do_insert = (state_q == S_PROBE) && term && (op_q == OP_INSERT)
			&& !match && can_place;
		do_delete = (state_q == S_PROBE) && term && (op_q == OP_DELETE) && match;
	end

	assign ram_we    = do_insert || do_delete;
	assign ram_waddr = do_insert ? place_idx : chk_idx_s1;
	assign ram_wdata = {(do_insert ? MARK_USED : MARK_DELETED), key_q};

	dhs_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			op_q          <= '0;
			key_q         <= '0;
			inc_q         <= '0;
			idx_q         <= '0;
			i_q           <= '0;
			chk_v_s1      <= 1'b0;
			chk_idx_s1    <= '0;
			i_s1          <= '0;
			free_found_q  <= 1'b0;
			free_idx_q    <= '0;
			valid_q       <= '0;
			count_q       <= '0;
			res_present_q <= 1'b0;
			res_status_q  <= ST_DONE;
			rsp_valid_q   <= 1'b0;
			out_present_q <= 1'b0;
			out_status_q  <= ST_DONE;
			out_count_q   <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q          <= req.op;
						key_q         <= req.key;
						res_present_q <= 1'b0;
						res_status_q  <= ST_DONE;
						// unused op code answers without touching the table
						state_q       <= start_key ? S_RES : S_FIN;
					end
				end
				S_RES: begin
					if (start_step) begin
						idx_q   <= IDX_W'(res_a);
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					if (!res_busy_a) begin
						inc_q        <= IDX_W'(res_a);
						i_q          <= '0;
						chk_v_s1     <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= S_PROBE;
					end
				end
				S_PROBE: begin
					// issue the next read while checking the last one
					chk_v_s1   <= 1'b1;
					chk_idx_s1 <= idx_q;
					i_s1       <= i_q;
					idx_q      <= idx_next;
					i_q        <= i_q + 1'b1;
					if (chk_v_s1 && !used && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= chk_idx_s1;
					end
					if (term) begin
						chk_v_s1      <= 1'b0;
						res_present_q <= match;
						state_q       <= S_FIN;
						if (do_insert) begin
							valid_q[place_idx] <= 1'b1;
							count_q            <= count_q + 1'b1;
						end
						if (do_delete && count_q != '0) begin
							count_q <= count_q - 1'b1;
						end
						if (op_q == OP_INSERT && !match && !can_place) begin
							res_status_q <= ST_FULL;
						end
						if (op_q == OP_DELETE && !match) begin
							res_status_q <= ST_ABSENT;
						end
					end
				end
				S_FIN: begin
					// wait here while the previous response is still held
					if (out_free) begin
						rsp_valid_q   <= 1'b1;
						out_present_q <= res_present_q;
						out_status_q  <= res_status_q;
						out_count_q   <= ELEM_W'(count_q);
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = rsp_valid_q;
	assign rsp.was_present   = out_present_q;
	assign rsp.status        = out_status_q;
	assign rsp.element_count = out_count_q;

	`DHS_ASSERT(a_count_range, count_q <= CNT_W'(SLOTS), "element count above table size")
	`DHS_ASSERT_IMP(a_write_in_probe, ram_we, state_q == S_PROBE && chk_v_s1, "slot write outside probe check")
	`DHS_ASSERT_IMP(a_count_needs_write, !$stable(count_q), $past(ram_we), "count moved without a slot write")
	`DHS_ASSERT_IMP(a_residue_state, res_busy_a || res_busy_b, state_q == S_RES || state_q == S_STEP, "residue unit busy outside hashing states")
endmodule

### rtl/core/dhs_ram.sv
// generic simple dual port ram, one write port, one registered read port
// no dependencies
module dhs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/core/dhs_residue.sv
// digit-serial residue unit: value mod modulus, one 4-bit digit per cycle
// depends on dhs_pkg
module dhs_residue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [dhs_pkg::PAD_W-1:0]   value,
	input  logic [dhs_pkg::DCNT_W-1:0]  digits,
	input  logic [dhs_pkg::RES_W-1:0]   modulus,
	output logic                        busy,
	output logic [dhs_pkg::RES_W-1:0]   res
);
	import dhs_pkg::*;

	logic [PAD_W-1:0]  val_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [RES_W-1:0]  r_q;
	logic              busy_q;
	logic [RES_W-1:0]  r_next;

	// digits enter msb first
	assign r_next = fold_digit(r_q, val_q[PAD_W-1 -: DIG_W], modulus);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= digits;
		end else if (busy_q) begin
			busy_q <= (cnt_q != DCNT_W'(1));
			cnt_q  <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
			r_q   <= '0;
		end else if (busy_q) begin
			val_q <= val_q << DIG_W;
			r_q   <= r_next;
		end
	end

	assign busy = busy_q;
	assign res  = r_q;
endmodule
